// File: rtl/uuid_v5_generator_top_defines.svh
// Assertion macros shared by the UUID v5 generator RTL.
// No dependencies.
`ifndef UUID_V5_GENERATOR_TOP_DEFINES_SVH
`define UUID_V5_GENERATOR_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define UV5_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define UV5_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/uv5_pkg.sv
// Shared constants, types and functions for the UUID v5 generator.
// No dependencies.
package uv5_pkg;

  localparam int LENGTH_COUNT_BITS = 64;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // register indexes on the config port
  localparam logic [0:0] REG_NS_HIGH = 1'b0;
  localparam logic [0:0] REG_NS_LOW  = 1'b1;

  typedef logic [31:0] word_t;

  // Control between sequencer and compression core.
  typedef struct packed {
    logic start;   // begin compression of the loaded block
    logic clear;   // restore initial chaining values
  } core_ctl_t;

  typedef struct packed {
    logic busy;
  } core_sts_t;

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

endpackage

// File: rtl/uv5_core.sv
// SHA-1 compression core: one round per cycle, message schedule in a 16-word window.
// Depends on uv5_pkg.
module uv5_core
  import uv5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  core_ctl_t   ctl,
  input  logic        wr_en,
  input  logic [3:0]  wr_idx,
  input  word_t       wr_data,
  output core_sts_t   sts,
  output word_t       h0,
  output word_t       h1,
  output word_t       h2,
  output word_t       h3
);

  word_t w_r [16];
  word_t a_r, b_r, c_r, d_r, e_r;
  word_t hv_r [5];
  logic  busy_r;
  logic [6:0] rnd_r;

  word_t f, k, t, wnew, wcur;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = K3;
    end
    wnew = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
    // first 16 rounds use loaded words in place, then the window slides
    wcur = (rnd_r < 7'd16) ? w_r[rnd_r[3:0]] : w_r[15];
    t = rotl(a_r, 5) + f + e_r + k + wcur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
      hv_r[0] <= H0_INIT; hv_r[1] <= H1_INIT; hv_r[2] <= H2_INIT;
      hv_r[3] <= H3_INIT; hv_r[4] <= H4_INIT;
    end else if (ctl.clear) begin
      hv_r[0] <= H0_INIT; hv_r[1] <= H1_INIT; hv_r[2] <= H2_INIT;
      hv_r[3] <= H3_INIT; hv_r[4] <= H4_INIT;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      rnd_r  <= '0;
      a_r <= hv_r[0]; b_r <= hv_r[1]; c_r <= hv_r[2]; d_r <= hv_r[3]; e_r <= hv_r[4];
    end else if (busy_r) begin
      if (rnd_r == 7'd80) begin
        busy_r <= 1'b0;
        hv_r[0] <= hv_r[0] + a_r; hv_r[1] <= hv_r[1] + b_r; hv_r[2] <= hv_r[2] + c_r;
        hv_r[3] <= hv_r[3] + d_r; hv_r[4] <= hv_r[4] + e_r;
      end else begin
        e_r <= d_r; d_r <= c_r; c_r <= rotl(b_r, 30); b_r <= a_r; a_r <= t;
        rnd_r <= rnd_r + 7'd1;
      end
    end
  end

  // Schedule window: from round 15 on, shift and append the next word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      w_r[wr_idx] <= wr_data;
    end else if (busy_r && rnd_r >= 7'd15 && rnd_r < 7'd79) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
    end
  end

  assign sts.busy = busy_r;
  assign h0 = hv_r[0];
  assign h1 = hv_r[1];
  assign h2 = hv_r[2];
  assign h3 = hv_r[3];

endmodule

// File: rtl/uuid_v5_generator_top.sv
// UUID v5 generator top level: SHA-1 over the 16 namespace bytes and the name bytes, one
// input transaction per name byte and one result per name. Input is stalled while an item
// is worked on. The first transaction of a message loads the namespace ahead of its own
// byte; a name byte is accepted and then written into the block, and an empty transaction
// is only accepted. A byte that completes a 64-byte block also waits for 80 rounds in the
// shared round unit, the chaining update and the hand-back to the sequencer. The closing
// transaction pads one byte per cycle up to the block end, compressing one or two blocks,
// and the result is then held until taken.
// Depends on uv5_pkg, uv5_core and uuid_v5_generator_top_defines.svh.
`include "uuid_v5_generator_top_defines.svh"
module uuid_v5_generator_top
  import uv5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_name_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_uuid_high,
  output logic [63:0] out_uuid_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NS   = 3'd1;
  localparam logic [2:0] ST_BYTE = 3'd2;
  localparam logic [2:0] ST_PAD  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [63:0] ns_hi_r, ns_lo_r;
  logic [LENGTH_COUNT_BITS-1:0] len_r;
  logic [63:0] len_fld;
  logic [5:0]  pos_r;
  logic        active_r, last_r, bv_r, pad_done_r, len_blk_r;
  logic [7:0]  byte_r;
  logic [23:0] acc_r;
  logic        put_en;
  logic [7:0]  put_byte;
  logic        count_it;
  core_ctl_t   ctl;
  core_sts_t   sts;
  logic        wr_en;
  word_t       wr_data;
  word_t       h0, h1, h2, h3;

  assign cfg_ready = (st_r == ST_IDLE);
  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  // chaining values hold still until the result is taken
  assign out_uuid_high = {h0, h1[31:16], 4'h5, h1[11:0]};
  assign out_uuid_low  = {2'b10, h2[29:0], h3};
  assign len_fld = 64'(len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_hi_r <= '0; ns_lo_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NS_HIGH: ns_hi_r <= cfg_data;
        REG_NS_LOW:  ns_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte selection and next state for the current step
  always_comb begin
    put_en = 1'b0; put_byte = '0; count_it = 1'b0; st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!active_r) st_nxt = ST_NS;
          else if (in_byte_valid) st_nxt = ST_BYTE;
          else if (in_last_item) st_nxt = ST_PAD;
        end
      end
      ST_NS: begin
        put_en = 1'b1; count_it = 1'b1;
        put_byte = pos_r[3] ? ns_lo_r[63 - 8*pos_r[2:0] -: 8]
                            : ns_hi_r[63 - 8*pos_r[2:0] -: 8];
        if (pos_r[3:0] == 4'd15) begin
          if (bv_r) st_nxt = ST_BYTE;
          else if (last_r) st_nxt = ST_PAD;
          else st_nxt = ST_IDLE;
        end
      end
      ST_BYTE: begin
        put_en = 1'b1; count_it = 1'b1; put_byte = byte_r;
        if (pos_r == 6'd63) st_nxt = ST_WAIT;
        else if (last_r) st_nxt = ST_PAD;
        else st_nxt = ST_IDLE;
      end
      ST_PAD: begin
        put_en = 1'b1;
        if (!pad_done_r) put_byte = PAD_BYTE;
        else if (len_blk_r && pos_r >= 6'd56) put_byte = len_fld[63 - 8*pos_r[2:0] -: 8];
        if (pos_r == 6'd63) st_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        // block done: more padding, the result, or back to input
        if (!sts.busy) begin
          if (pad_done_r) st_nxt = len_blk_r ? ST_OUT : ST_PAD;
          else st_nxt = last_r ? ST_PAD : ST_IDLE;
        end
      end
      ST_OUT: if (!out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign wr_en   = put_en && (pos_r[1:0] == 2'd3);
  assign wr_data = {acc_r, put_byte};
  assign ctl.start = put_en && (pos_r == 6'd63);
  assign ctl.clear = (st_r == ST_OUT) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; active_r <= 1'b0; last_r <= 1'b0; bv_r <= 1'b0;
      len_r <= '0; pos_r <= '0; pad_done_r <= 1'b0; len_blk_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE && in_valid) begin
        byte_r <= in_name_byte; bv_r <= in_byte_valid; last_r <= in_last_item;
        active_r <= 1'b1;
      end else if (ctl.clear) begin
        active_r <= 1'b0; last_r <= 1'b0;
      end
      if (ctl.clear) begin
        len_r <= '0; pos_r <= '0; pad_done_r <= 1'b0; len_blk_r <= 1'b0;
      end else if (put_en) begin
        pos_r <= pos_r + 6'd1;
        if (count_it) len_r <= len_r + LENGTH_COUNT_BITS'(8);
        if (st_r == ST_PAD && !pad_done_r) begin
          pad_done_r <= 1'b1;
          // length fits behind the pad byte only when it lands before byte 56
          len_blk_r <= (pos_r < 6'd56);
        end
      end else if (st_r == ST_WAIT && !sts.busy && pad_done_r) begin
        len_blk_r <= 1'b1;
      end
    end
  end

  // leading bytes of the current word
  always_ff @(posedge clk) begin
    if (put_en) begin
      case (pos_r[1:0])
        2'd0: acc_r[23:16] <= put_byte;
        2'd1: acc_r[15:8]  <= put_byte;
        2'd2: acc_r[7:0]   <= put_byte;
        default: ;
      endcase
    end
  end

  uv5_core u_core (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .wr_en(wr_en), .wr_idx(pos_r[5:2]),
    .wr_data(wr_data), .sts(sts), .h0(h0), .h1(h1), .h2(h2), .h3(h3)
  );

  `UV5_ASSERT_IMPL(a_out_idle_core, clk, rst_n, out_valid, !sts.busy,
    "result offered while core busy")
  `UV5_ASSERT_IMPL(a_no_write_busy, clk, rst_n, wr_en, !sts.busy,
    "block word written during compression")
  `UV5_ASSERT_NEXT(a_start_busy, clk, rst_n, ctl.start, sts.busy,
    "core did not start")

endmodule
